@@ design/ssd_pkg.sv @@
// Shared types, constants and helper functions for the seven-segment display driver.
// Depends on nothing; every other design file except ssd_checker imports it.
`timescale 1ns / 1ps

package ssd_pkg;

  localparam int unsigned NUMBER_W = 14;
  localparam logic [NUMBER_W-1:0] VALUE_MAX = 14'd9999;
  localparam logic [NUMBER_W-1:0] PLACE_THOUSANDS = 14'd1000;
  localparam logic [NUMBER_W-1:0] PLACE_HUNDREDS = 14'd100;
  localparam logic [NUMBER_W-1:0] PLACE_TENS = 14'd10;
  localparam logic [7:0] SEGMENTS_OFF = 8'hFF;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_SET  = 1'b1
  } cmd_t;

  typedef enum logic [0:0] {
    REG_REFRESH_PERIOD      = 1'b0,
    REG_BLANK_LEADING_ZEROS = 1'b1
  } reg_index_t;

  typedef logic [3:0] digit_t;

  // Item as it leaves the digit split pipeline. rem holds what is left below
  // the last digit extracted so far.
  typedef struct packed {
    cmd_t                command;
    logic [NUMBER_W-1:0] number;
    digit_t              thousands;
    digit_t              hundreds;
    logic [9:0]          rem;
  } split_item_t;

  typedef struct packed {
    digit_t              digit;
    logic [NUMBER_W-1:0] rest;
  } split_t;

  // Extracts one decimal digit at a constant place by parallel compares.
  // Values that would give a digit above 9 are clipped; those are rejected anyway.
  function automatic split_t split_place(input logic [NUMBER_W-1:0] value,
                                         input logic [NUMBER_W-1:0] place);
    digit_t q;
    split_t r;
    q = '0;
    for (int k = 1; k < 10; k++) begin
      if (value >= NUMBER_W'(k) * place) begin
        q = 4'(k);
      end
    end
    r.digit = q;
    r.rest  = value - NUMBER_W'(q) * place;
    return r;
  endfunction

  // Active-low segment pattern, bit i drives segment line i.
  function automatic logic [7:0] seg_pattern(input digit_t d);
    logic [7:0] p;
    case (d)
      4'd0:    p = 8'h14;
      4'd1:    p = 8'h77;
      4'd2:    p = 8'h4C;
      4'd3:    p = 8'h45;
      4'd4:    p = 8'h27;
      4'd5:    p = 8'h85;
      4'd6:    p = 8'h84;
      4'd7:    p = 8'h57;
      4'd8:    p = 8'h04;
      4'd9:    p = 8'h05;
      default: p = SEGMENTS_OFF;
    endcase
    return p;
  endfunction

endpackage

@@ design/seven_segment_mux_driver.sv @@
// Top level of the four-digit multiplexed seven-segment display driver.
// Depends on ssd_pkg, ssd_digit_split and ssd_display_core.
`timescale 1ns / 1ps

// The block takes one transaction per clock cycle unless the output side stalls, and
// returns exactly one result for each. A transaction passes through the input
// register, the decimal split pipeline (thousands, then hundreds) and the state
// and output register, where tens and units are split and every tick and every
// accepted set of a new number updates the display state.
// A set transaction (tuser = 1) loads a number up to 9999; larger values are
// flagged as rejected and ignored. A tick transaction (tuser = 0) stands for
// one millisecond; after refresh_period ticks the next digit is shown on
// digit_lines (one-hot) and segment_lines (active low). Results always carry
// the held line levels. Configuration is written through cfg_we, cfg_index and
// cfg_data only while no transaction is in flight; the user, not the block, ensures it.
module seven_segment_mux_driver (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [13:0] number, [15:14] zero
  input  logic        s_tuser,   // [0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] segment_lines, [11:8] digit_lines, [15:12] zero
  output logic [1:0]  m_tuser,   // [0] refreshed, [1] number_rejected
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import ssd_pkg::*;

  logic        split_valid;
  logic        split_ready;
  split_item_t split_item;

  ssd_digit_split u_split (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .out_valid (split_valid),
    .out_ready (split_ready),
    .out_item  (split_item)
  );

  ssd_display_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (split_valid),
    .in_ready  (split_ready),
    .in_item   (split_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

@@ design/ssd_digit_split.sv @@
// Input register and decimal digit split pipeline (thousands, then hundreds).
// Depends on ssd_pkg.
`timescale 1ns / 1ps

module ssd_digit_split (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [15:0]            s_tdata,   // [13:0] number, [15:14] zero
  input  logic                   s_tuser,   // [0] command
  output logic                   out_valid,
  input  logic                   out_ready,
  output ssd_pkg::split_item_t   out_item
);
  import ssd_pkg::*;

  logic                v0;
  cmd_t                command0;
  logic [NUMBER_W-1:0] number0;
  logic                v1;
  split_item_t         item1;
  logic                v2;
  split_item_t         item2;

  logic        en0;
  logic        en1;
  logic        en2;
  split_t      thou;
  split_t      hund;
  split_item_t item1_next;
  split_item_t item2_next;

  // Each stage loads when it is empty or its content moves on this cycle.
  assign en2      = !v2 || out_ready;
  assign en1      = !v1 || en2;
  assign en0      = !v0 || en1;
  assign s_tready = en0;

  always_comb begin
    thou = split_place(number0, PLACE_THOUSANDS);
    item1_next           = '0;
    item1_next.command   = command0;
    item1_next.number    = number0;
    item1_next.thousands = thou.digit;
    item1_next.rem       = thou.rest[9:0];
  end

  always_comb begin
    hund = split_place({4'b0, item1.rem}, PLACE_HUNDREDS);
    item2_next          = item1;
    item2_next.hundreds = hund.digit;
    item2_next.rem      = hund.rest[9:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en0) begin
        v0 <= s_tvalid;
      end
      if (en1) begin
        v1 <= v0;
      end
      if (en2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en0 && s_tvalid) begin
      command0 <= cmd_t'(s_tuser);
      number0  <= s_tdata[NUMBER_W-1:0];
    end
    if (en1 && v0) begin
      item1 <= item1_next;
    end
    if (en2 && v1) begin
      item2 <= item2_next;
    end
  end

  assign out_valid = v2;
  assign out_item  = item2;

endmodule

@@ design/ssd_display_core.sv @@
// Display state (digits, scan position, tick counter, held lines), configuration
// registers and the output register. Depends on ssd_pkg.
`timescale 1ns / 1ps

module ssd_display_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ssd_pkg::split_item_t in_item,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [15:0]          m_tdata,   // [7:0] segment_lines, [11:8] digit_lines, [15:12] zero
  output logic [1:0]           m_tuser    // [0] refreshed, [1] number_rejected
);
  import ssd_pkg::*;

  logic [7:0]          refresh_period;
  logic                blank_leading_zeros;
  digit_t              digits [4];
  logic [NUMBER_W-1:0] last_number;
  logic [1:0]          scan_position;
  logic [7:0]          ticks_elapsed;
  logic [7:0]          held_segments;
  logic [3:0]          held_digit_select;
  logic                refreshed;
  logic                number_rejected;
  logic                ovalid;

  logic       take;
  logic       is_set;
  logic       rejected_now;
  logic       load_number;
  logic       refresh_now;
  logic [7:0] ticks_inc;
  logic [1:0] lead_zeros;
  logic [1:0] pos;
  split_t     tens;

  assign in_ready = !ovalid || m_tready;
  assign take     = in_valid && in_ready;
  assign is_set   = (in_item.command == CMD_SET);

  assign rejected_now = is_set && (in_item.number > VALUE_MAX);
  assign load_number  = is_set && !rejected_now && (in_item.number != last_number);

  assign ticks_inc   = (ticks_elapsed == 8'hFF) ? 8'hFF : ticks_elapsed + 8'd1;
  assign refresh_now = !is_set && (ticks_inc >= refresh_period);

  always_comb begin
    tens = split_place({4'b0, in_item.rem}, PLACE_TENS);
    if (digits[0] != 4'd0) begin
      lead_zeros = 2'd0;
    end else if (digits[1] != 4'd0) begin
      lead_zeros = 2'd1;
    end else if (digits[2] != 4'd0) begin
      lead_zeros = 2'd2;
    end else begin
      lead_zeros = 2'd3;
    end
    pos = scan_position;
    if (blank_leading_zeros && (pos < lead_zeros)) begin
      pos = lead_zeros;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      refresh_period      <= 8'd1;
      blank_leading_zeros <= 1'b1;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_REFRESH_PERIOD:      refresh_period      <= cfg_data;
        REG_BLANK_LEADING_ZEROS: blank_leading_zeros <= cfg_data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        digits[i] <= '0;
      end
      last_number       <= '0;
      scan_position     <= '0;
      ticks_elapsed     <= '0;
      held_segments     <= SEGMENTS_OFF;
      held_digit_select <= '0;
      ovalid            <= 1'b0;
    end else begin
      if (take) begin
        ovalid <= 1'b1;
        if (load_number) begin
          last_number <= in_item.number;
          digits[0]   <= in_item.thousands;
          digits[1]   <= in_item.hundreds;
          digits[2]   <= tens.digit;
          digits[3]   <= tens.rest[3:0];
        end
        if (!is_set) begin
          if (refresh_now) begin
            held_segments     <= seg_pattern(digits[pos]);
            held_digit_select <= 4'b0001 << pos;
            scan_position     <= pos + 2'd1;
            ticks_elapsed     <= '0;
          end else begin
            ticks_elapsed <= ticks_inc;
          end
        end
      end else if (m_tready) begin
        ovalid <= 1'b0;
      end
    end
  end

  // Flags are payload of the result transaction and need no reset.
  always_ff @(posedge clk) begin
    if (take) begin
      refreshed       <= refresh_now;
      number_rejected <= rejected_now;
    end
  end

  assign m_tvalid = ovalid;
  assign m_tdata  = {4'b0, held_digit_select, held_segments};
  assign m_tuser  = {number_rejected, refreshed};

endmodule

@@ design/ssd_checker.sv @@
// Port-level assertions for the seven-segment display driver, bound to the top level.
// Depends only on the top-level ports.
`timescale 1ns / 1ps

module ssd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // No result may appear in the cycle right after a reset cycle.
  a_idle_after_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_digit_onehot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0(m_tdata[11:8]))
    else $error("more than one digit line selected");

  // A tick never rejects and a set never refreshes.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("refreshed and rejected both set");

  // Until the first refresh, no digit is selected and all segments are dark.
  a_dark_when_unselected: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[11:8] == 4'd0) |-> (m_tdata[7:0] == 8'hFF))
    else $error("segments lit without a selected digit");

endmodule

bind seven_segment_mux_driver ssd_checker u_ssd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

@@ tb/seven_segment_mux_driver_tb.sv @@
// Self-checking testbench for the four-digit seven-segment display driver.
// Depends on ssd_pkg and the seven_segment_mux_driver design; predicts every result itself.
`timescale 1ns / 1ps

module seven_segment_mux_driver_tb;
  import ssd_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  // Active-low patterns for digit values 9 down to 0; index by digit value.
  localparam logic [9:0][7:0] SEG_CODES = {
    8'h05, 8'h04, 8'h57, 8'h84, 8'h85, 8'h27, 8'h45, 8'h4C, 8'h77, 8'h14
  };

  typedef struct packed {
    logic [7:0] segments;
    logic [3:0] digit_select;
    logic       refreshed;
    logic       rejected;
  } display_lines_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // [13:0] number, [15:14] zero
  logic        s_tuser = 1'b0; // [0] command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // [7:0] segment_lines, [11:8] digit_lines, [15:12] zero
  logic [1:0]  m_tuser;        // [0] refreshed, [1] number_rejected
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  seven_segment_mux_driver uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted display state and register copies.
  logic [7:0]     refresh_period = 8'd1;
  logic           blank_zeros = 1'b1;
  digit_t         digits [4] = '{default: 4'd0};
  logic [13:0]    shown_number = '0;
  logic [1:0]     scan_pos = '0;
  logic [7:0]     ticks = '0;
  logic [7:0]     held_segments = SEGMENTS_OFF;
  logic [3:0]     held_select = '0;
  display_lines_t pending_lines [$];

  int unsigned errors = 0;
  int unsigned stall_cnt = 0;
  int unsigned quiet_cycles = 0;
  bit          calm = 1'b0;
  display_lines_t got_lines, want_lines;

  function automatic display_lines_t advance_display(input cmd_t cmd, input logic [13:0] num);
    display_lines_t r;
    logic [8:0] elapsed;
    logic [1:0] pos;
    int lead;
    logic [13:0] v;
    r.refreshed = 1'b0;
    r.rejected = 1'b0;
    if (cmd == CMD_SET) begin
      if (num > VALUE_MAX) begin
        r.rejected = 1'b1;
      end else if (num != shown_number) begin
        shown_number = num;
        v = num;
        for (int i = 3; i >= 0; i--) begin
          digits[i] = 4'(v % 10);
          v = 14'(v / 10);
        end
      end
    end else begin
      elapsed = {1'b0, ticks} + 9'd1;
      if (elapsed > 9'd255) elapsed = 9'd255;
      if (elapsed >= {1'b0, refresh_period}) begin
        pos = scan_pos;
        if (blank_zeros) begin
          lead = 0;
          while (lead < 3 && digits[lead] == 4'd0) lead++;
          if (int'(pos) < lead) pos = 2'(lead);
        end
        held_segments = SEG_CODES[digits[pos]];
        held_select = 4'b0001 << pos;
        scan_pos = pos + 2'd1;
        ticks = '0;
        r.refreshed = 1'b1;
      end else begin
        ticks = elapsed[7:0];
      end
    end
    r.segments = held_segments;
    r.digit_select = held_select;
    return r;
  endfunction

  // Sends one item, with an occasional burst of idle cycles ahead of it.
  task automatic send_item(input cmd_t cmd, input logic [13:0] num);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {2'b00, num};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_lines.push_back(advance_display(cmd, num));
  endtask

  // Stops sending and waits until every predicted result has been seen.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_lines.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_regs(input logic [7:0] period, input logic blank);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_REFRESH_PERIOD;
    cfg_data <= period;
    @(posedge clk);
    cfg_index <= REG_BLANK_LEADING_ZEROS;
    cfg_data <= {7'd0, blank};
    @(posedge clk);
    cfg_we <= 1'b0;
    refresh_period = period;
    blank_zeros = blank;
  endtask

  function automatic logic [13:0] pick_number();
    case ($urandom_range(0, 3))
      0: return 14'($urandom_range(0, 9));
      1: return 14'($urandom_range(0, 99));
      2: return 14'($urandom_range(0, 999));
      default: return 14'($urandom_range(0, 9999));
    endcase
  endfunction

  task automatic test_directed();
    send_item(CMD_TICK, 14'd0);      // all digits zero: only the last digit shows
    send_item(CMD_SET, 14'd0);       // same as the reset value, nothing changes
    send_item(CMD_SET, 14'd9999);
    repeat (4) send_item(CMD_TICK, 14'd0);
    send_item(CMD_SET, 14'd10000);
    send_item(CMD_SET, 14'd16383);
    send_item(CMD_SET, 14'd9999);
    send_item(CMD_SET, 14'd1000);
    repeat (2) send_item(CMD_TICK, 14'd16383);
    send_item(CMD_SET, 14'd1);
    repeat (2) send_item(CMD_TICK, 14'd5555);
    send_item(CMD_SET, 14'd10);
    send_item(CMD_TICK, 14'd0);
    send_item(CMD_SET, 14'd100);
    send_item(CMD_TICK, 14'd0);
    send_item(CMD_SET, 14'd2468);
    send_item(CMD_TICK, 14'd0);
  endtask

  // A zero period refreshes on every tick; blanking off scans all four digits.
  task automatic test_zero_period();
    write_regs(8'd0, 1'b0);
    send_item(CMD_SET, 14'd7);
    repeat (5) send_item(CMD_TICK, 14'd0);
    send_item(CMD_SET, 14'd3579);
    repeat (5) send_item(CMD_TICK, 14'd10922);
  endtask

  task automatic test_random_phase(input logic [7:0] period, input logic blank,
                                   input int unsigned count);
    int unsigned roll;
    write_regs(period, blank);
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) send_item(CMD_TICK, 14'($urandom_range(0, 16383)));
      else if (roll < 78) send_item(CMD_SET, shown_number);
      else if (roll < 84) send_item(CMD_SET, 14'($urandom_range(10000, 16383)));
      else send_item(CMD_SET, pick_number());
    end
  endtask

  // Output side stalls in random bursts, except in the calm tail of the run.
  always @(posedge clk) begin
    if (stall_cnt > 1) begin
      stall_cnt <= stall_cnt - 1;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_cnt <= $urandom_range(1, 13);
      m_tready <= 1'b0;
    end else begin
      stall_cnt <= 0;
      m_tready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_lines.segments = m_tdata[7:0];
      got_lines.digit_select = m_tdata[11:8];
      got_lines.refreshed = m_tuser[0];
      got_lines.rejected = m_tuser[1];
      if (pending_lines.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transaction, expected none, actual %0h",
                 $time, got_lines);
      end else begin
        want_lines = pending_lines.pop_front();
        check_field("segment_lines", want_lines.segments, got_lines.segments);
        check_field("digit_lines", want_lines.digit_select, got_lines.digit_select);
        check_field("refreshed", want_lines.refreshed, got_lines.refreshed);
        check_field("number_rejected", want_lines.rejected, got_lines.rejected);
      end
    end
  end

  // Ends the run if no transaction moves on either side for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_zero_period();
    test_random_phase(8'd1, 1'b1, 250);
    test_random_phase(8'd255, 1'b0, 150);
    test_random_phase(8'd2, 1'b0, 250);
    test_random_phase(8'd7, 1'b1, 250);
    test_random_phase(8'd1, 1'b0, 200);
    calm = 1'b1;
    test_random_phase(8'd3, 1'b1, 200);
    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/ssd_pkg.sv
design/ssd_digit_split.sv
design/ssd_display_core.sv
design/seven_segment_mux_driver.sv
design/ssd_checker.sv
tb/seven_segment_mux_driver_tb.sv
